// ===== rtl/core/intel_hex_record_encoder_assert.svh =====
// Assertion macros for the Intel HEX record encoder.
`ifndef INTEL_HEX_RECORD_ENCODER_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define IHEX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define IHEX_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/ihex_enc_pkg.sv =====
// Package: constants, phase type and character helpers of the Intel HEX encoder.
`default_nettype none

package ihex_enc_pkg;

  // Record sizing
  localparam int unsigned RECORD_BYTES = 16;
  localparam int unsigned BUF_DEPTH    = 16;
  localparam int unsigned BUF_AW       = 4;
  localparam int unsigned FILL_W       = 5;
  localparam int unsigned RECORD_LIMIT = (RECORD_BYTES < 1) ? 1 :
                                         ((RECORD_BYTES > BUF_DEPTH) ? BUF_DEPTH : RECORD_BYTES);
  localparam logic [FILL_W-1:0] LIMIT_FILL = FILL_W'(RECORD_LIMIT);

  // Address and register port
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_START_ADDRESS = 1'b0;  // word index of start_address

  // Last step index within the sequencer phases
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] HEAD_LAST = 4'd8;
  localparam logic [STEP_W-1:0] SUM_LAST  = 4'd2;
  localparam logic [STEP_W-1:0] END_LAST  = 4'd11;

  // Characters
  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_NL    = 7'h0A;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_ONE   = 7'h31;
  localparam logic [6:0] CHAR_F     = 7'h46;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEAD,
    PH_DATA,
    PH_SUM,
    PH_END
  } phase_e;

  // Nibble to uppercase hex digit
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    return (nib < 4'd10) ? 7'(CHAR_ZERO + wide) : 7'(7'h37 + wide);
  endfunction

  // Characters of the end-of-file record ":00000001FF" and its newline
  function automatic logic [6:0] end_char(input logic [STEP_W-1:0] idx);
    logic [6:0] c;
    unique case (idx)
      4'd0:        c = CHAR_COLON;
      4'd8:        c = CHAR_ONE;
      4'd9, 4'd10: c = CHAR_F;
      4'd11:       c = CHAR_NL;
      default:     c = CHAR_ZERO;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ihex_enc_if.sv =====
// Interfaces: image byte channel and hex character channel.
`default_nettype none

interface ihex_byte_if;
  logic       valid;
  logic       ready;
  logic       carries_byte;
  logic [7:0] data_byte;
  logic       final_req;

  modport source (output valid, carries_byte, data_byte, final_req, input ready);
  modport sink   (input valid, carries_byte, data_byte, final_req, output ready);
endinterface

interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       last_of_run;

  modport source (output valid, text_char, last_of_run, input ready);
  modport sink   (input valid, text_char, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/intel_hex_record_encoder.sv =====
// Intel HEX record encoder: byte buffer memory, record sequencer and APB register.
//
// Image bytes arrive one per transfer and are written into a 16-entry buffer memory;
// a transfer that only buffers a byte is taken at once while the encoder is idle. When
// the buffer reaches the record size, or a transfer carries final_req, a data record is
// sent as one ASCII character per transfer: 12 + 2*n characters for a record of n bytes,
// followed at the end of the image by the 12 characters of the end record. The single
// character output register passes one character per cycle while the receiver is ready,
// so a full 16-byte record is 44 characters. No new byte is taken while a record is being
// sent; the next byte is taken as soon as the last character sits in the output register.
// start_address lies at byte address 0 of the APB port and must be written while idle.
`default_nettype none
`include "intel_hex_record_encoder_assert.svh"

module intel_hex_record_encoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  ihex_byte_if.sink                           byte_in_i,
  ihex_char_if.source                         hex_out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ihex_enc_pkg::PADDR_W-1:0]    paddr,
  input  logic [ihex_enc_pkg::PDATA_W-1:0]    pwdata,
  output logic [ihex_enc_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);

  // ---------------------------------------------------------------------------
  // Declarations
  // ---------------------------------------------------------------------------
  logic [ihex_enc_pkg::ADDR_W-1:0]  start_addr_q;
  logic                             cfg_we;

  logic [7:0] mem [ihex_enc_pkg::BUF_DEPTH];
  logic [7:0] rd_data_q;
  logic       mem_we;
  logic [ihex_enc_pkg::BUF_AW-1:0] wr_addr;
  logic [ihex_enc_pkg::BUF_AW-1:0] rd_addr;

  logic [ihex_enc_pkg::FILL_W-1:0] fill_q, fill_d, fill_inc, fill_new;
  logic [7:0]                      sum_q, sum_d, sum_new;
  logic [ihex_enc_pkg::ADDR_W-1:0] offset_q, offset_d;

  logic                            in_accept;
  logic                            rec_now;
  logic [ihex_enc_pkg::ADDR_W-1:0] rec_addr;
  logic [7:0]                      hdr_sum;

  ihex_enc_pkg::phase_e            phase_q, phase_d;
  logic [ihex_enc_pkg::STEP_W-1:0] step_q, step_d;
  logic [ihex_enc_pkg::FILL_W-1:0] rd_idx_q, rd_idx_d;
  logic                            nib_q, nib_d;
  logic                            end_q, end_d;
  logic [ihex_enc_pkg::FILL_W-1:0] len_q;
  logic [ihex_enc_pkg::ADDR_W-1:0] addr_q;
  logic [7:0]                      chk_q;

  logic       out_valid_q;
  logic [6:0] out_char_q;
  logic       out_last_q;
  logic       out_load;
  logic [6:0] out_char_d;
  logic       out_last_d;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[2] == ihex_enc_pkg::REG_START_ADDRESS);

  always_comb begin
    prdata = '0;
    if (paddr[2] == ihex_enc_pkg::REG_START_ADDRESS) begin
      prdata = ihex_enc_pkg::PDATA_W'(start_addr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_addr_q <= '0;
    end else if (cfg_we) begin
      start_addr_q <= pwdata[ihex_enc_pkg::ADDR_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Input transfer: buffer bookkeeping and record decision
  // ---------------------------------------------------------------------------
  assign byte_in_i.ready = (phase_q == ihex_enc_pkg::PH_IDLE);
  assign in_accept       = byte_in_i.valid && byte_in_i.ready;

  assign fill_inc = fill_q + 1'b1;
  assign fill_new = byte_in_i.carries_byte ? fill_inc : fill_q;
  assign sum_new  = byte_in_i.carries_byte ? 8'(sum_q + byte_in_i.data_byte) : sum_q;
  assign rec_now  = (byte_in_i.carries_byte && (fill_inc >= ihex_enc_pkg::LIMIT_FILL)) ||
                    (byte_in_i.final_req && (fill_new != '0));
  assign rec_addr = 16'(start_addr_q + offset_q);
  // sum of length, address bytes and data; the checksum is its negation
  assign hdr_sum  = 8'({3'b000, fill_new} + rec_addr[15:8] + rec_addr[7:0] + sum_new);

  always_comb begin
    fill_d   = fill_q;
    sum_d    = sum_q;
    offset_d = offset_q;
    if (in_accept) begin
      fill_d = rec_now ? '0 : fill_new;
      sum_d  = rec_now ? '0 : sum_new;
      if (byte_in_i.final_req) begin
        offset_d = '0;
      end else if (rec_now) begin
        offset_d = 16'(offset_q + {11'd0, fill_new});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      sum_q    <= '0;
      offset_q <= '0;
    end else begin
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      offset_q <= offset_d;
    end
  end

  // record header fields, latched when the record is started
  always_ff @(posedge clk_i) begin
    if (in_accept && rec_now) begin
      len_q  <= fill_new;
      addr_q <= rec_addr;
      chk_q  <= 8'(8'd0 - hdr_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // Record buffer memory: one write port, one registered read port.
  // The read address follows the sequencer's next index; a write to the same
  // entry in the same cycle is forwarded.
  // ---------------------------------------------------------------------------
  assign mem_we  = in_accept && byte_in_i.carries_byte;
  assign wr_addr = fill_q[ihex_enc_pkg::BUF_AW-1:0];
  assign rd_addr = rd_idx_d[ihex_enc_pkg::BUF_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= byte_in_i.data_byte;
    end
    if (mem_we && (wr_addr == rd_addr)) begin
      rd_data_q <= byte_in_i.data_byte;
    end else begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  assign out_load = (phase_q != ihex_enc_pkg::PH_IDLE) && (!out_valid_q || hex_out_o.ready);

  always_comb begin
    phase_d  = phase_q;
    step_d   = step_q;
    rd_idx_d = rd_idx_q;
    nib_d    = nib_q;
    end_d    = end_q;
    unique case (phase_q)
      ihex_enc_pkg::PH_IDLE: begin
        if (in_accept) begin
          step_d   = '0;
          rd_idx_d = '0;
          nib_d    = 1'b0;
          end_d    = byte_in_i.final_req;
          if (rec_now) begin
            phase_d = ihex_enc_pkg::PH_HEAD;
          end else if (byte_in_i.final_req) begin
            phase_d = ihex_enc_pkg::PH_END;
          end
        end
      end
      ihex_enc_pkg::PH_HEAD: begin
        if (out_load) begin
          if (step_q == ihex_enc_pkg::HEAD_LAST) begin
            step_d  = '0;
            phase_d = ihex_enc_pkg::PH_DATA;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ihex_enc_pkg::PH_DATA: begin
        if (out_load) begin
          if (!nib_q) begin
            nib_d = 1'b1;
          end else begin
            nib_d    = 1'b0;
            rd_idx_d = rd_idx_q + 1'b1;
            if ((rd_idx_q + 1'b1) == len_q) begin
              phase_d = ihex_enc_pkg::PH_SUM;
            end
          end
        end
      end
      ihex_enc_pkg::PH_SUM: begin
        if (out_load) begin
          if (step_q == ihex_enc_pkg::SUM_LAST) begin
            step_d  = '0;
            phase_d = end_q ? ihex_enc_pkg::PH_END : ihex_enc_pkg::PH_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ihex_enc_pkg::PH_END: begin
        if (out_load) begin
          if (step_q == ihex_enc_pkg::END_LAST) begin
            step_d  = '0;
            end_d   = 1'b0;
            phase_d = ihex_enc_pkg::PH_IDLE;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: phase_d = ihex_enc_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ihex_enc_pkg::PH_IDLE;
      step_q   <= '0;
      rd_idx_q <= '0;
      nib_q    <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      step_q   <= step_d;
      rd_idx_q <= rd_idx_d;
      nib_q    <= nib_d;
      end_q    <= end_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: character of the current step
  // ---------------------------------------------------------------------------
  always_comb begin
    out_char_d = ihex_enc_pkg::CHAR_NL;
    out_last_d = 1'b0;
    unique case (phase_q)
      ihex_enc_pkg::PH_HEAD: begin
        unique case (step_q)
          4'd0:    out_char_d = ihex_enc_pkg::CHAR_COLON;
          4'd1:    out_char_d = ihex_enc_pkg::hex_char({3'b000, len_q[4]});
          4'd2:    out_char_d = ihex_enc_pkg::hex_char(len_q[3:0]);
          4'd3:    out_char_d = ihex_enc_pkg::hex_char(addr_q[15:12]);
          4'd4:    out_char_d = ihex_enc_pkg::hex_char(addr_q[11:8]);
          4'd5:    out_char_d = ihex_enc_pkg::hex_char(addr_q[7:4]);
          4'd6:    out_char_d = ihex_enc_pkg::hex_char(addr_q[3:0]);
          default: out_char_d = ihex_enc_pkg::CHAR_ZERO;  // record type 00
        endcase
      end
      ihex_enc_pkg::PH_DATA: begin
        out_char_d = ihex_enc_pkg::hex_char(nib_q ? rd_data_q[3:0] : rd_data_q[7:4]);
      end
      ihex_enc_pkg::PH_SUM: begin
        unique case (step_q)
          4'd0:    out_char_d = ihex_enc_pkg::hex_char(chk_q[7:4]);
          4'd1:    out_char_d = ihex_enc_pkg::hex_char(chk_q[3:0]);
          default: out_char_d = ihex_enc_pkg::CHAR_NL;
        endcase
        out_last_d = (step_q == ihex_enc_pkg::SUM_LAST) && !end_q;
      end
      ihex_enc_pkg::PH_END: begin
        out_char_d = ihex_enc_pkg::end_char(step_q);
        out_last_d = (step_q == ihex_enc_pkg::END_LAST);
      end
      default: begin
        out_char_d = ihex_enc_pkg::CHAR_NL;
        out_last_d = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (hex_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign hex_out_o.valid       = out_valid_q;
  assign hex_out_o.text_char   = out_char_q;
  assign hex_out_o.last_of_run = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IHEX_ASSERT(a_fill_below_limit, fill_q < ihex_enc_pkg::LIMIT_FILL, "buffer fill reached record size")
  `IHEX_ASSERT(a_data_index, (phase_q == ihex_enc_pkg::PH_DATA) |-> (rd_idx_q < len_q), "data index past record length")
  `IHEX_ASSERT(a_last_ends_run, (out_load && out_last_d) |=> (phase_q == ihex_enc_pkg::PH_IDLE), "sequencer busy after last character")
  `IHEX_ASSERT(a_final_clears_offset, (in_accept && byte_in_i.final_req) |=> (offset_q == '0), "offset not cleared at end of image")
  `IHEX_ASSERT_NEVER(a_end_without_final, (phase_q == ihex_enc_pkg::PH_END) && !end_q, "end record without end of image")

endmodule

`default_nettype wire
